FILE: hdl/rss_pkg.sv
package rss_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;

  localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_BITS   = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int PROD_BITS = 2 * SAMPLE_BITS;

  // fixed field widths of the channels
  localparam int IN_SAMPLE_W = 16;
  localparam int OUT_W       = 16;
  localparam int VAR_W       = 31;

  localparam int MUL_CNT_W = $clog2(SAMPLE_BITS);
  localparam int DIV_CNT_W = $clog2(2 * SAMPLE_BITS);

  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_LAUNCH,
    ST_DIVIDE,
    ST_MEANSQ,
    ST_VAR,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OUT_W-1:0] count;
    logic [OUT_W-1:0] max_value;
    logic [OUT_W-1:0] mean;
    logic [VAR_W-1:0] variance;
    logic [OUT_W-1:0] std_dev;
    logic             empty_res;
    logic             saturated;
  } result_t;

endpackage

FILE: hdl/rss_in_if.sv
interface rss_in_if;
  logic                               valid;
  logic                               ready;
  logic                               func;
  logic [rss_pkg::IN_SAMPLE_W-1:0]    sample;

  modport source(output valid, func, sample, input ready);
  modport sink(input valid, func, sample, output ready);
endinterface

FILE: hdl/rss_out_if.sv
interface rss_out_if;
  logic                          valid;
  logic                          ready;
  logic [rss_pkg::OUT_W-1:0]     count;
  logic [rss_pkg::OUT_W-1:0]     max_value;
  logic [rss_pkg::OUT_W-1:0]     mean;
  logic [rss_pkg::VAR_W-1:0]     variance;
  logic [rss_pkg::OUT_W-1:0]     std_dev;
  logic                          empty_res;
  logic                          saturated;

  modport source(output valid, count, max_value, mean, variance, std_dev, empty_res,
                 saturated, input ready);
  modport sink(input valid, count, max_value, mean, variance, std_dev, empty_res,
               saturated, output ready);
endinterface

FILE: hdl/rss_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
module rss_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [rss_pkg::SAMPLE_BITS-1:0]   a,
  input  logic [rss_pkg::SAMPLE_BITS-1:0]   b,
  output logic                              done,
  output logic [rss_pkg::PROD_BITS-1:0]     prod
);

  logic [rss_pkg::PROD_BITS-1:0]   mcand;
  logic [rss_pkg::SAMPLE_BITS-1:0] mplier;
  logic [rss_pkg::MUL_CNT_W-1:0]   cnt;
  logic                            busy;
  logic                            last;

  assign last = (cnt == rss_pkg::MUL_CNT_W'(rss_pkg::SAMPLE_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= rss_pkg::PROD_BITS'(a);
      mplier <= b;
      prod   <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

FILE: hdl/rss_div.sv
// Two restoring dividers sharing one divisor, one quotient bit per cycle each.
// Lane a: sum / count (SAMPLE_BITS quotient bits). Lane b: sumsq / count
// (2*SAMPLE_BITS quotient bits). The upper dividend slices are always below
// the count, so they seed the partial remainders directly.
module rss_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [rss_pkg::COUNT_BITS-1:0]    divisor,
  input  logic [rss_pkg::SUM_BITS-1:0]      num_a,
  input  logic [rss_pkg::SQ_BITS-1:0]       num_b,
  output logic                              done,
  output logic [rss_pkg::SAMPLE_BITS-1:0]   quo_a,
  output logic [rss_pkg::PROD_BITS-1:0]     quo_b
);

  localparam int S = rss_pkg::SAMPLE_BITS;
  localparam int C = rss_pkg::COUNT_BITS;

  logic [C-1:0]                  d;
  logic [C-1:0]                  rem_a;
  logic [C-1:0]                  rem_b;
  logic [rss_pkg::DIV_CNT_W-1:0] step;
  logic                          busy;
  logic                          last;
  logic                          run_a;
  logic [C:0]                    trial_a;
  logic [C:0]                    trial_b;
  logic                          ge_a;
  logic                          ge_b;

  assign last    = (step == rss_pkg::DIV_CNT_W'(2 * S - 1));
  assign run_a   = (step < rss_pkg::DIV_CNT_W'(S));
  assign trial_a = {rem_a, quo_a[S-1]};
  assign trial_b = {rem_b, quo_b[2*S-1]};
  assign ge_a    = (trial_a >= {1'b0, d});
  assign ge_b    = (trial_b >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d     <= divisor;
      rem_a <= num_a[S+C-1:S];
      quo_a <= num_a[S-1:0];
      rem_b <= num_b[2*S+C-1:2*S];
      quo_b <= num_b[2*S-1:0];
    end else if (busy) begin
      if (run_a) begin
        rem_a <= ge_a ? C'(trial_a - {1'b0, d}) : trial_a[C-1:0];
        quo_a <= {quo_a[S-2:0], ge_a};
      end
      rem_b <= ge_b ? C'(trial_b - {1'b0, d}) : trial_b[C-1:0];
      quo_b <= {quo_b[2*S-2:0], ge_b};
    end
  end

endmodule

FILE: hdl/rss_root.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module rss_root (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [rss_pkg::PROD_BITS-1:0]     radicand,
  output logic                              done,
  output logic [rss_pkg::SAMPLE_BITS-1:0]   root
);

  localparam int S = rss_pkg::SAMPLE_BITS;

  logic [2*S-1:0]                vs;
  logic [S:0]                    rem;
  logic [rss_pkg::MUL_CNT_W-1:0] cnt;
  logic                          busy;
  logic                          last;
  logic [S+2:0]                  part;
  logic [S+2:0]                  trial;
  logic                          ge;

  assign last  = (cnt == rss_pkg::MUL_CNT_W'(S - 1));
  assign part  = {rem, vs[2*S-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign ge    = (part >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vs   <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      // remainder never exceeds twice the partial root, so S+1 bits suffice
      rem  <= ge ? (S+1)'(part - trial) : (S+1)'(part);
      root <= {root[S-2:0], ge};
      vs   <= vs << 2;
    end
  end

endmodule

FILE: hdl/running_sample_statistics_top.sv
// Running sample statistics: count, maximum, floor mean, variance and
// integer standard deviation over the samples added since the last clear.
//
// item channel (valid/ready): func selects add sample or clear; sample is
// the unsigned value to add. One transaction is processed at a time.
// result channel (valid/ready): one transaction per item, holding the
// statistics after that item. empty_res flags a zero count (statistics 0);
// saturated flags that a sample was dropped because the count was full.
//
// An added sample passes through the bit-serial units in turn: a shift-add
// square of the sample, the two-lane restoring divider, a second shift-add
// for mean squared and the digit-by-digit square root. When the count is
// full the square is skipped; when it is zero the result needs no unit.
// item.ready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next item is taken while the receiver
// stalls, and its result waits until that register is free.
// Reset (rst, synchronous) clears all accumulators and drops any pending
// transaction.
module running_sample_statistics_top (
  input  logic        clk,
  input  logic        rst,
  rss_in_if.sink      item,
  rss_out_if.source   result
);

  localparam int S = rss_pkg::SAMPLE_BITS;
  localparam int C = rss_pkg::COUNT_BITS;

  rss_pkg::state_t state;
  rss_pkg::state_t state_next;

  logic [C-1:0]                  sample_count;
  logic [rss_pkg::SUM_BITS-1:0]  running_sum;
  logic [rss_pkg::SQ_BITS-1:0]   running_sum_squares;
  logic [S-1:0]                  largest_sample;
  logic                          overflow_seen;

  logic                          func_q;
  logic [S-1:0]                  sample_q;
  logic [S-1:0]                  sample_in;

  logic                          accept;
  logic                          count_full;
  logic                          is_clear;
  logic                          res_free;

  logic                          in_ready;
  logic                          mul_start;
  logic                          mul_sel_mean;
  logic                          div_start;
  logic                          root_start;
  logic                          acc_en;
  logic                          res_load;

  logic [S-1:0]                  mul_op;
  logic                          mul_done;
  logic [rss_pkg::PROD_BITS-1:0] prod;
  logic                          div_done;
  logic [S-1:0]                  mean_q;
  logic [rss_pkg::PROD_BITS-1:0] msq_q;
  logic                          root_done;
  logic [S-1:0]                  sd_q;

  logic [rss_pkg::PROD_BITS-1:0] var_calc;
  logic [rss_pkg::PROD_BITS-1:0] var_q;

  rss_pkg::result_t              res;
  logic                          res_valid;

  assign sample_in  = S'(item.sample);
  assign accept     = item.valid && item.ready;
  assign count_full = (sample_count == '1);
  assign is_clear   = (item.func == rss_pkg::FUNC_CLEAR);
  assign res_free   = !res_valid || result.ready;
  assign item.ready = in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rss_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_clear || count_full) begin
            state_next = rss_pkg::ST_ACCUM;
          end else begin
            state_next = rss_pkg::ST_SQUARE;
          end
        end
      end
      rss_pkg::ST_SQUARE: begin
        if (mul_done) begin
          state_next = rss_pkg::ST_ACCUM;
        end
      end
      rss_pkg::ST_ACCUM: begin
        state_next = rss_pkg::ST_LAUNCH;
      end
      rss_pkg::ST_LAUNCH: begin
        if (sample_count == '0) begin
          state_next = rss_pkg::ST_DONE;
        end else begin
          state_next = rss_pkg::ST_DIVIDE;
        end
      end
      rss_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = rss_pkg::ST_MEANSQ;
        end
      end
      rss_pkg::ST_MEANSQ: begin
        if (mul_done) begin
          state_next = rss_pkg::ST_VAR;
        end
      end
      rss_pkg::ST_VAR: begin
        state_next = rss_pkg::ST_ROOT;
      end
      rss_pkg::ST_ROOT: begin
        if (root_done) begin
          state_next = rss_pkg::ST_DONE;
        end
      end
      rss_pkg::ST_DONE: begin
        if (res_free) begin
          state_next = rss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rss_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready     = 1'b0;
    mul_start    = 1'b0;
    mul_sel_mean = 1'b0;
    div_start    = 1'b0;
    root_start   = 1'b0;
    acc_en       = 1'b0;
    res_load     = 1'b0;
    case (state)
      rss_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        mul_start = accept && !is_clear && !count_full;
      end
      rss_pkg::ST_ACCUM: begin
        acc_en = 1'b1;
      end
      rss_pkg::ST_LAUNCH: begin
        div_start = (sample_count != '0);
      end
      rss_pkg::ST_DIVIDE: begin
        mul_sel_mean = 1'b1;
        mul_start    = div_done;
      end
      rss_pkg::ST_VAR: begin
        root_start = 1'b1;
      end
      rss_pkg::ST_DONE: begin
        res_load = res_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q   <= item.func;
      sample_q <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count        <= '0;
      running_sum         <= '0;
      running_sum_squares <= '0;
      largest_sample      <= '0;
      overflow_seen       <= 1'b0;
    end else if (acc_en) begin
      if (func_q == rss_pkg::FUNC_CLEAR) begin
        sample_count        <= '0;
        running_sum         <= '0;
        running_sum_squares <= '0;
        largest_sample      <= '0;
        overflow_seen       <= 1'b0;
      end else if (count_full) begin
        overflow_seen <= 1'b1;
      end else begin
        sample_count        <= sample_count + 1'b1;
        running_sum         <= running_sum + rss_pkg::SUM_BITS'(sample_q);
        running_sum_squares <= running_sum_squares + rss_pkg::SQ_BITS'(prod);
        if (sample_q > largest_sample) begin
          largest_sample <= sample_q;
        end
      end
    end
  end

  assign mul_op = mul_sel_mean ? mean_q : sample_in;

  rss_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_op),
    .b     (mul_op),
    .done  (mul_done),
    .prod  (prod)
  );

  rss_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (sample_count),
    .num_a   (running_sum),
    .num_b   (running_sum_squares),
    .done    (div_done),
    .quo_a   (mean_q),
    .quo_b   (msq_q)
  );

  // msq_q holds floor(sumsq/n); prod holds mean squared here
  assign var_calc = (msq_q >= prod) ? (msq_q - prod) : '0;

  always_ff @(posedge clk) begin
    if (root_start) begin
      var_q <= var_calc;
    end
  end

  rss_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (var_calc),
    .done     (root_done),
    .root     (sd_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.count     <= rss_pkg::OUT_W'(sample_count);
      res.max_value <= rss_pkg::OUT_W'(largest_sample);
      res.saturated <= overflow_seen;
      if (sample_count == '0) begin
        res.mean      <= '0;
        res.variance  <= '0;
        res.std_dev   <= '0;
        res.empty_res <= 1'b1;
      end else begin
        res.mean      <= rss_pkg::OUT_W'(mean_q);
        res.variance  <= rss_pkg::VAR_W'(var_q);
        res.std_dev   <= rss_pkg::OUT_W'(sd_q);
        res.empty_res <= 1'b0;
      end
    end
  end

  assign result.valid     = res_valid;
  assign result.count     = res.count;
  assign result.max_value = res.max_value;
  assign result.mean      = res.mean;
  assign result.variance  = res.variance;
  assign result.std_dev   = res.std_dev;
  assign result.empty_res = res.empty_res;
  assign result.saturated = res.saturated;

endmodule

FILE: hdl/rss_checker.sv
module rss_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rss_pkg::OUT_W-1:0]     count,
  input logic [rss_pkg::OUT_W-1:0]     mean,
  input logic [rss_pkg::VAR_W-1:0]     variance,
  input logic [rss_pkg::OUT_W-1:0]     std_dev,
  input logic                          empty_res
);

  logic [32:0] sd_sq;
  logic [32:0] sd1_sq;

  assign sd_sq  = 33'(std_dev) * 33'(std_dev);
  assign sd1_sq = (33'(std_dev) + 33'd1) * (33'(std_dev) + 33'd1);

  a_reset_no_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // one transaction in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while previous one still in work");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(count) && $stable(variance)))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((empty_res == (count == '0)) &&
                   (!empty_res || (mean == '0 && variance == '0 && std_dev == '0))))
    else $error("empty flag inconsistent with result");

  a_root_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sd_sq <= 33'(variance) && sd1_sq > 33'(variance)))
    else $error("std_dev is not the floor root of variance");

endmodule

bind running_sample_statistics_top rss_checker u_rss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .count     (result.count),
  .mean      (result.mean),
  .variance  (result.variance),
  .std_dev   (result.std_dev),
  .empty_res (result.empty_res)
);

FILE: dv/testbench.sv
module testbench;

  typedef struct {
    rss_pkg::func_t   func;
    logic [15:0]      sample;
    int unsigned      gap;
    bit               drain;
  } pending_item_t;

  logic clk;
  logic rst;

  rss_in_if  item_ch();
  rss_out_if result_ch();

  running_sample_statistics_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  pending_item_t     pending_items[$];
  rss_pkg::result_t  expected_stats[$];

  // predictor copy of the accumulators
  logic [15:0] acc_count;
  logic [31:0] acc_sum;
  logic [47:0] acc_sumsq;
  logic [15:0] acc_peak;
  bit          acc_dropped;

  int unsigned items_taken;
  int unsigned results_seen;
  int unsigned total_items;
  int unsigned mismatches;
  int unsigned idle_wait;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  bit          sender_quiet;
  bit          receiver_quiet;
  bit          took_now;
  pending_item_t cur_item;

  localparam int unsigned HOLD_AT_RESULT = 250;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned END_SETTLE     = 120;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [15:0] floor_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[15:0];
  endfunction

  // updates the accumulators for one transaction and returns the statistics after it
  function automatic rss_pkg::result_t apply_item(rss_pkg::func_t f, logic [15:0] s);
    logic [63:0]      m;
    logic [63:0]      q2;
    logic [63:0]      msq;
    logic [63:0]      spread;
    rss_pkg::result_t r;
    if (f == rss_pkg::FUNC_CLEAR) begin
      acc_count   = '0;
      acc_sum     = '0;
      acc_sumsq   = '0;
      acc_peak    = '0;
      acc_dropped = 1'b0;
    end else if (acc_count == '1) begin
      acc_dropped = 1'b1;
    end else begin
      acc_count = acc_count + 16'd1;
      acc_sum   = acc_sum + 32'(s);
      acc_sumsq = acc_sumsq + 48'(s) * 48'(s);
      if (s > acc_peak) acc_peak = s;
    end
    r = '0;
    r.count     = acc_count;
    r.max_value = acc_peak;
    r.empty_res = (acc_count == '0);
    r.saturated = acc_dropped;
    if (acc_count != '0) begin
      m      = 64'(acc_sum) / 64'(acc_count);
      q2     = 64'(acc_sumsq) / 64'(acc_count);
      msq    = m * m;
      spread = (q2 >= msq) ? q2 - msq : 64'd0;
      r.mean     = m[15:0];
      r.variance = spread[rss_pkg::VAR_W-1:0];
      r.std_dev  = floor_root(spread);
    end
    return r;
  endfunction

  function automatic logic [15:0] draw_sample(int unsigned kind, logic [15:0] base);
    logic [15:0] picks[4];
    picks = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE};
    case (kind)
      0: return 16'($urandom_range(0, 65535));
      1: return base + 16'($urandom_range(0, 15));
      2: return base;
      3: return picks[$urandom_range(0, 3)];
      default: return 16'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_item(rss_pkg::func_t f, logic [15:0] s, bit drain = 1'b0);
    pending_item_t it;
    it.func   = f;
    it.sample = s;
    it.drain  = drain;
    it.gap    = sender_quiet ? 0 : $urandom_range(0, 14);
    pending_items.push_back(it);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      idle_wait = 0;
    end else begin
      took_now = item_ch.valid && item_ch.ready;
      if (took_now) begin
        expected_stats.push_back(apply_item(rss_pkg::func_t'(item_ch.func),
                                            item_ch.sample));
        items_taken <= items_taken + 1;
        idle_wait = 0;
      end
      if (!item_ch.valid || took_now) begin
        // a drain item waits until every outstanding result has come back
        if (pending_items.size() != 0 && idle_wait >= pending_items[0].gap &&
            (!pending_items[0].drain || (!took_now && items_taken == results_seen))) begin
          cur_item = pending_items.pop_front();
          item_ch.valid  <= 1'b1;
          item_ch.func   <= cur_item.func;
          item_ch.sample <= cur_item.sample;
        end else begin
          item_ch.valid <= 1'b0;
          idle_wait++;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    rss_pkg::result_t got;
    rss_pkg::result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.count     = result_ch.count;
        got.max_value = result_ch.max_value;
        got.mean      = result_ch.mean;
        got.variance  = result_ch.variance;
        got.std_dev   = result_ch.std_dev;
        got.empty_res = result_ch.empty_res;
        got.saturated = result_ch.saturated;
        if (expected_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result transaction %0d: count %0d mean %0d",
                     results_seen, got.count, got.mean);
        end else begin
          want = expected_stats.pop_front();
          if (got.count !== want.count || got.max_value !== want.max_value ||
              got.mean !== want.mean || got.variance !== want.variance ||
              got.std_dev !== want.std_dev || got.empty_res !== want.empty_res ||
              got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result %0d (expected / actual):", results_seen);
              $display("  count %0d / %0d  max %0d / %0d  mean %0d / %0d",
                       want.count, got.count, want.max_value, got.max_value,
                       want.mean, got.mean);
              $display("  variance %0d / %0d  std_dev %0d / %0d",
                       want.variance, got.variance, want.std_dev, got.std_dev);
              $display("  empty %0b / %0b  saturated %0b / %0b",
                       want.empty_res, got.empty_res, want.saturated, got.saturated);
            end
          end
        end
        results_seen <= results_seen + 1;
        if (results_seen % 64 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
        stall_left = receiver_quiet ? 0 : $urandom_range(0, 14);
        if (results_seen + 1 == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned burst_len;
    int unsigned kind;
    logic [15:0] base;
    bit          drain_done;
    int unsigned random_target;

    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.func    = rss_pkg::FUNC_ADD;
    item_ch.sample  = '0;
    result_ch.ready = 1'b0;
    items_taken     = 0;
    results_seen    = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    receiver_quiet  = 1'b0;
    sender_quiet    = 1'b0;
    drain_done      = 1'b0;
    acc_count       = '0;
    acc_sum         = '0;
    acc_sumsq       = '0;
    acc_peak        = '0;
    acc_dropped     = 1'b0;

    // directed: empty clears, extremes, alternating bit patterns
    push_item(rss_pkg::FUNC_CLEAR, 16'hFFFF);
    push_item(rss_pkg::FUNC_CLEAR, 16'h0000);
    push_item(rss_pkg::FUNC_ADD,   16'h0000);
    push_item(rss_pkg::FUNC_ADD,   16'hFFFF);
    push_item(rss_pkg::FUNC_ADD,   16'hFFFF);
    push_item(rss_pkg::FUNC_ADD,   16'hAAAA);
    push_item(rss_pkg::FUNC_ADD,   16'h5555);
    push_item(rss_pkg::FUNC_ADD,   16'h0001);
    push_item(rss_pkg::FUNC_ADD,   16'h8000);
    push_item(rss_pkg::FUNC_CLEAR, 16'h5555);
    push_item(rss_pkg::FUNC_ADD,   16'hFFFF);
    push_item(rss_pkg::FUNC_ADD,   16'hFFFF);
    push_item(rss_pkg::FUNC_ADD,   16'hFFFF);
    push_item(rss_pkg::FUNC_CLEAR, 16'hAAAA);
    push_item(rss_pkg::FUNC_ADD,   16'h0000);
    push_item(rss_pkg::FUNC_ADD,   16'hFFFF);
    push_item(rss_pkg::FUNC_CLEAR, 16'h0000);
    push_item(rss_pkg::FUNC_ADD,   16'h0001);
    push_item(rss_pkg::FUNC_ADD,   16'h0000);
    push_item(rss_pkg::FUNC_ADD,   16'h0002);
    push_item(rss_pkg::FUNC_ADD,   16'h7FFF);
    push_item(rss_pkg::FUNC_CLEAR, 16'hFFFF);

    // random: clear followed by a burst of samples, with stray clears as noise
    random_target = pending_items.size() + 880;
    while (pending_items.size() < random_target) begin
      sender_quiet = ($urandom_range(0, 3) == 0);
      push_item(rss_pkg::FUNC_CLEAR, 16'($urandom_range(0, 65535)),
                !drain_done && pending_items.size() >= 450);
      if (pending_items.size() >= 451) drain_done = 1'b1;
      burst_len = $urandom_range(1, 40);
      kind      = $urandom_range(0, 4);
      base      = 16'($urandom_range(0, 65535));
      for (int i = 0; i < burst_len; i++) begin
        if ($urandom_range(0, 24) == 0)
          push_item(rss_pkg::FUNC_CLEAR, 16'($urandom_range(0, 65535)));
        else
          push_item(rss_pkg::FUNC_ADD, draw_sample(kind, base));
      end
    end

    // wait for all results once more, then a short tail
    sender_quiet = 1'b0;
    push_item(rss_pkg::FUNC_CLEAR, 16'hFFFF, 1'b1);
    push_item(rss_pkg::FUNC_ADD, 16'h1234);
    push_item(rss_pkg::FUNC_ADD, 16'hFFFF);
    total_items = pending_items.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (items_taken != total_items || results_seen != items_taken);
    repeat (END_SETTLE) @(posedge clk);

    if (expected_stats.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d expected results never arrived", expected_stats.size());
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
